@@ hdl/swtr_pkg.sv @@
// Shared constants for the sliding window tile reassigner.
// Used by the tile divider and by the top level; depends on nothing.
`default_nettype none

package swtr_pkg;

    localparam int COORD_W = 32;
    localparam int SLOT_W = 8;
    localparam int FUNC_W = 2;
    localparam int RANGE_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int STACK_DEPTH = 256;
    localparam int DEFAULT_MAX_RANGE = 7;

    // Camera tile quotient, signed, and the divider operand widths.
    localparam int TILE_W = COORD_W + 2;
    localparam int DIV_W = COORD_W + 1;
    // Window arithmetic on tile differences.
    localparam int DIFF_W = COORD_W + 4;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CENTER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CAMERA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RANGE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HALF_SPAN = 8'd1;

    localparam logic [RANGE_W-1:0] RESET_WINDOW_RANGE = 3'd2;
    localparam logic [COORD_W-1:0] RESET_HALF_SPAN = 32'd65536;

endpackage

`default_nettype wire

@@ hdl/swtr_div.sv @@
// Restoring divider that yields floor(num / den) for the camera tile.
// Takes the magnitude form of the dividend; uses swtr_pkg.
`default_nettype none

module swtr_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [swtr_pkg::DIV_W-1:0]        mag,
    input  wire logic                              neg,
    input  wire logic [swtr_pkg::DIV_W-1:0]        den,
    output logic                                   done,
    output logic [swtr_pkg::TILE_W-1:0]            quo
);
    import swtr_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DIV_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    shifted;
    logic              fits;

    // Each step brings down one dividend bit, most significant first.
    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign fits = shifted >= {1'b0, den_reg};

    always_comb begin
        rem_next = rem_reg;
        q_next = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            rem_next = '0;
            q_next = mag;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DIV_W'(shifted - {1'b0, den_reg}) : shifted[DIV_W-1:0];
            q_next = {q_reg[DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start && !busy_reg) begin
            den_reg <= den;
            neg_reg <= neg;
        end
    end

    // For a negative dividend floor(n/d) equals the complement of ~n / d.
    assign done = done_reg;
    assign quo = neg_reg ? ~{1'b0, q_reg} : {1'b0, q_reg};

endmodule

`default_nettype wire

@@ hdl/sliding_window_tile_reassigner.sv @@
// Sliding window tile reassigner: top level with slot table, stacks and sequencer.
// Uses swtr_pkg and the camera tile divider swtr_div.
`default_nettype none

// A load word writes one slot; a set-center word sets the window center.
// A camera word that finds stale slots pending pops one and presents one
// result word through the pop read and write-back states; while that result
// waits in the output register, the next pop waits too. Otherwise the camera
// tile is found by the shared bit-serial divider, one axis after the other; if the
// tile is unchanged the word ends there with no result. If it moved, the block
// walks the new window one coordinate a cycle, then scans the first (2r+1)^2
// slots of the slot table one slot a cycle through its registered read port.
// The slot table is cleared at reset by per-slot valid flags, so no clearing
// pass is needed. Configuration is written through the cfg channel by the user
// only while idle; the block itself does not enforce this.
module sliding_window_tile_reassigner #(
    parameter int MAX_RANGE = swtr_pkg::DEFAULT_MAX_RANGE
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [swtr_pkg::COORD_W-1:0]      cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [swtr_pkg::FUNC_W-1:0]       s_func,
    input  wire logic [swtr_pkg::SLOT_W-1:0]       s_slot,
    input  wire logic signed [swtr_pkg::COORD_W-1:0] s_chunk_x,
    input  wire logic signed [swtr_pkg::COORD_W-1:0] s_chunk_z,
    input  wire logic signed [swtr_pkg::COORD_W-1:0] s_camera_x,
    input  wire logic signed [swtr_pkg::COORD_W-1:0] s_camera_z,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [swtr_pkg::SLOT_W-1:0]            m_out_slot,
    output logic signed [swtr_pkg::COORD_W-1:0]    m_new_x,
    output logic signed [swtr_pkg::COORD_W-1:0]    m_new_z
);
    import swtr_pkg::*;

    localparam int SIDE_W = $clog2(2 * MAX_RANGE + 2);
    localparam int SCAN_W = $clog2((2 * MAX_RANGE + 1) * (2 * MAX_RANGE + 1) + 1);
    localparam int SLOTS = 1 << SLOT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POPRD = 3'd1;
    localparam logic [2:0] ST_POPWR = 3'd2;
    localparam logic [2:0] ST_DIVX  = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_FRESH = 3'd6;
    localparam logic [2:0] ST_SCAN  = 3'd7;

    // Configuration.
    logic [RANGE_W-1:0] range_reg;
    logic [COORD_W-1:0] span_reg;
    logic [RANGE_W-1:0] r_eff;
    logic [COORD_W-1:0] h_eff;
    logic [SIDE_W-1:0]  side;
    logic [SCAN_W-1:0]  slot_count;
    logic [RANGE_W:0]   two_r;

    // Sequencer and window state.
    logic [2:0]         state_reg;
    logic [COORD_W-1:0] center_x_reg, center_z_reg;
    logic [COORD_W-1:0] cam_x_reg, cam_z_reg;
    logic [TILE_W-1:0]  tile_x_reg, tile_z_reg;
    logic [DIFF_W-1:0]  dcx_reg, dcz_reg;
    logic [DIFF_W-1:0]  ixr_reg, izr_reg;
    logic [COORD_W-1:0] x0_reg, z0_reg;
    logic [SIDE_W-1:0]  xi_reg, zi_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               rdv_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [CNT_W-1:0]   stale_cnt_reg, fresh_cnt_reg;

    // Memories: slot table with valid flags, and the two pending stacks.
    logic [2*COORD_W-1:0] slot_mem [SLOTS];
    logic [SLOTS-1:0]     slot_vld_reg;
    logic [SLOT_W-1:0]    stale_mem [STACK_DEPTH];
    logic [2*COORD_W-1:0] fresh_mem [STACK_DEPTH];
    logic [2*COORD_W-1:0] slot_rd_reg;
    logic                 slot_rdv_reg;
    logic [SLOT_W-1:0]    stale_rd_reg;
    logic [2*COORD_W-1:0] fresh_rd_reg;
    logic                 fresh_hit_reg;

    // Result register.
    logic                 m_valid_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [COORD_W-1:0]   m_x_reg, m_z_reg;

    // Divider hookup.
    logic                 div_start_reg;
    logic                 div_done;
    logic [TILE_W-1:0]    div_quo;
    logic [COORD_W-1:0]   div_pos;
    logic [TILE_W-1:0]    div_num;
    logic [DIV_W-1:0]     div_mag;
    logic [DIV_W-1:0]     div_den;

    logic                 in_acc;
    logic                 out_free;
    logic [SLOT_W-1:0]    pop_idx;
    logic [CNT_W-1:0]     pop_dec;
    logic [COORD_W-1:0]   pop_x, pop_z;
    logic [DIFF_W-1:0]    wx, wz, wsx, wsz;
    logic                 fresh_push, stale_push;
    logic [COORD_W-1:0]   scan_x, scan_z;
    logic [SLOT_W-1:0]    scan_addr;
    logic                 slot_we;
    logic [SLOT_W-1:0]    slot_wa;
    logic [2*COORD_W-1:0] slot_wd;

    assign r_eff = (range_reg > RANGE_W'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE) : range_reg;
    assign h_eff = (span_reg == '0) ? COORD_W'(1) : span_reg;
    assign side = SIDE_W'({r_eff, 1'b1});
    assign slot_count = SCAN_W'(side) * SCAN_W'(side);
    assign two_r = {r_eff, 1'b0};

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RESET_WINDOW_RANGE;
            span_reg <= RESET_HALF_SPAN;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_WINDOW_RANGE) begin
                range_reg <= cfg_data[RANGE_W-1:0];
            end else if (cfg_index == CFG_TILE_HALF_SPAN) begin
                span_reg <= cfg_data;
            end
        end
    end

    // Tile of a position: floor((pos + h) / 2h), x from camera z, z from camera x.
    assign div_pos = (state_reg == ST_DIVX) ? cam_z_reg : cam_x_reg;
    assign div_num = {{2{div_pos[COORD_W-1]}}, div_pos} + {2'b00, h_eff};
    assign div_mag = div_num[TILE_W-1] ? ~div_num[DIV_W-1:0] : div_num[DIV_W-1:0];
    assign div_den = {h_eff, 1'b0};

    swtr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .mag     (div_mag),
        .neg     (div_num[TILE_W-1]),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Pop side: the top stale slot pairs with the fresh entry at the same depth.
    assign pop_dec = stale_cnt_reg - 1'b1;
    assign pop_idx = pop_dec[SLOT_W-1:0];
    assign pop_x = fresh_hit_reg ? fresh_rd_reg[COORD_W-1:0] : '0;
    assign pop_z = fresh_hit_reg ? fresh_rd_reg[2*COORD_W-1:COORD_W] : '0;

    // Window walk: a coordinate is new when it lies outside the old window.
    // |x - cx| <= r holds exactly when 0 <= (ix - cx) + xi <= 2r.
    assign wx = dcx_reg + DIFF_W'(xi_reg);
    assign wz = dcz_reg + DIFF_W'(zi_reg);
    assign fresh_push = !((!wx[DIFF_W-1] && wx <= DIFF_W'(two_r)) &&
                          (!wz[DIFF_W-1] && wz <= DIFF_W'(two_r)));

    // Slot scan: slots never written read as coordinate zero.
    assign scan_x = slot_rdv_reg ? slot_rd_reg[COORD_W-1:0] : '0;
    assign scan_z = slot_rdv_reg ? slot_rd_reg[2*COORD_W-1:COORD_W] : '0;
    assign wsx = ixr_reg - {{(DIFF_W-COORD_W){scan_x[COORD_W-1]}}, scan_x};
    assign wsz = izr_reg - {{(DIFF_W-COORD_W){scan_z[COORD_W-1]}}, scan_z};
    assign stale_push = rdv_reg &&
        !((!wsx[DIFF_W-1] && wsx <= DIFF_W'(two_r)) &&
          (!wsz[DIFF_W-1] && wsz <= DIFF_W'(two_r)));
    assign scan_addr = SLOT_W'(scan_reg);

    // One write port on the slot table, shared by loads and pops.
    always_comb begin
        slot_we = 1'b0;
        slot_wa = s_slot;
        slot_wd = {s_chunk_z, s_chunk_x};
        if (in_acc && s_func == FUNC_LOAD) begin
            slot_we = 1'b1;
        end else if (state_reg == ST_POPWR && out_free) begin
            slot_we = 1'b1;
            slot_wa = stale_rd_reg;
            slot_wd = {pop_z, pop_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[scan_addr];
        slot_rdv_reg <= slot_vld_reg[scan_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FRESH && fresh_push && !fresh_cnt_reg[CNT_W-1]) begin
            fresh_mem[fresh_cnt_reg[SLOT_W-1:0]] <= {z0_reg + COORD_W'(zi_reg),
                                                     x0_reg + COORD_W'(xi_reg)};
        end
        if (state_reg == ST_SCAN && stale_push && !stale_cnt_reg[CNT_W-1]) begin
            stale_mem[stale_cnt_reg[SLOT_W-1:0]] <= rd_slot_reg;
        end
        stale_rd_reg <= stale_mem[pop_idx];
        fresh_rd_reg <= fresh_mem[pop_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_vld_reg <= '0;
            center_x_reg <= '0;
            center_z_reg <= '0;
            stale_cnt_reg <= '0;
            fresh_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            // The divider starts on a camera word with nothing to pop, and
            // again for the second axis once the first one is done.
            div_start_reg <= (state_reg == ST_IDLE && in_acc && s_func == FUNC_CAMERA &&
                              stale_cnt_reg == '0) ||
                             (state_reg == ST_DIVX && div_done);
            if (slot_we) begin
                slot_vld_reg[slot_wa] <= 1'b1;
            end
            // In the pop write-back the output register is reloaded instead.
            if (m_valid_reg && m_ready && state_reg != ST_POPWR) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_func == FUNC_CENTER) begin
                            center_x_reg <= s_chunk_x;
                            center_z_reg <= s_chunk_z;
                        end else if (s_func == FUNC_CAMERA) begin
                            cam_x_reg <= s_camera_x;
                            cam_z_reg <= s_camera_z;
                            if (stale_cnt_reg != '0) begin
                                state_reg <= ST_POPRD;
                            end else begin
                                state_reg <= ST_DIVX;
                            end
                        end
                    end
                end
                ST_POPRD: begin
                    fresh_hit_reg <= {1'b0, pop_idx} < fresh_cnt_reg;
                    state_reg <= ST_POPWR;
                end
                ST_POPWR: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_slot_reg <= stale_rd_reg;
                        m_x_reg <= pop_x;
                        m_z_reg <= pop_z;
                        stale_cnt_reg <= pop_dec;
                        if (fresh_cnt_reg != '0) begin
                            fresh_cnt_reg <= fresh_cnt_reg - 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIVX: begin
                    if (div_done) begin
                        tile_x_reg <= div_quo;
                        state_reg <= ST_DIVZ;
                    end
                end
                ST_DIVZ: begin
                    if (div_done) begin
                        tile_z_reg <= div_quo;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (tile_x_reg == {{2{center_x_reg[COORD_W-1]}}, center_x_reg} &&
                        tile_z_reg == {{2{center_z_reg[COORD_W-1]}}, center_z_reg}) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        dcx_reg <= {{2{tile_x_reg[TILE_W-1]}}, tile_x_reg} -
                                   {{4{center_x_reg[COORD_W-1]}}, center_x_reg};
                        dcz_reg <= {{2{tile_z_reg[TILE_W-1]}}, tile_z_reg} -
                                   {{4{center_z_reg[COORD_W-1]}}, center_z_reg};
                        ixr_reg <= {{2{tile_x_reg[TILE_W-1]}}, tile_x_reg} + DIFF_W'(r_eff);
                        izr_reg <= {{2{tile_z_reg[TILE_W-1]}}, tile_z_reg} + DIFF_W'(r_eff);
                        x0_reg <= tile_x_reg[COORD_W-1:0] - COORD_W'(r_eff);
                        z0_reg <= tile_z_reg[COORD_W-1:0] - COORD_W'(r_eff);
                        xi_reg <= '0;
                        zi_reg <= '0;
                        state_reg <= ST_FRESH;
                    end
                end
                ST_FRESH: begin
                    if (fresh_push && !fresh_cnt_reg[CNT_W-1]) begin
                        fresh_cnt_reg <= fresh_cnt_reg + 1'b1;
                    end
                    if (zi_reg == side - 1'b1) begin
                        zi_reg <= '0;
                        if (xi_reg == side - 1'b1) begin
                            scan_reg <= '0;
                            rdv_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end else begin
                            xi_reg <= xi_reg + 1'b1;
                        end
                    end else begin
                        zi_reg <= zi_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    // Read issue and check run one slot apart.
                    if (stale_push && !stale_cnt_reg[CNT_W-1]) begin
                        stale_cnt_reg <= stale_cnt_reg + 1'b1;
                    end
                    rd_slot_reg <= scan_addr;
                    if (scan_reg != slot_count) begin
                        scan_reg <= scan_reg + 1'b1;
                        rdv_reg <= 1'b1;
                    end else begin
                        rdv_reg <= 1'b0;
                        if (!rdv_reg) begin
                            center_x_reg <= tile_x_reg[COORD_W-1:0];
                            center_z_reg <= tile_z_reg[COORD_W-1:0];
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_slot = m_slot_reg;
    assign m_new_x = m_x_reg;
    assign m_new_z = m_z_reg;

    // A result word only ever comes out of the pop write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_POPWR))
        else $error("result raised outside pop write-back");

    assert property (@(posedge aclk) disable iff (!aresetn)
        stale_cnt_reg <= CNT_W'(STACK_DEPTH) && fresh_cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // The window walk only fills the fresh stack, the scan only the stale one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FRESH |=> stale_cnt_reg == $past(stale_cnt_reg))
        else $error("stale stack changed during window walk");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |=> fresh_cnt_reg == $past(fresh_cnt_reg))
        else $error("fresh stack changed during slot scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POPRD) |-> stale_cnt_reg != '0)
        else $error("pop started on an empty stale stack");

endmodule

`default_nettype wire

@@ test/sliding_window_tile_reassigner_test.sv @@
// Self-checking testbench for the sliding window tile reassigner.
// Depends on swtr_pkg and the sliding_window_tile_reassigner top level.
`timescale 1ns / 100ps

module sliding_window_tile_reassigner_test;
    import swtr_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] chunk_x;
        logic [COORD_W-1:0] chunk_z;
        logic [COORD_W-1:0] camera_x;
        logic [COORD_W-1:0] camera_z;
    } tile_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
    } reassign_t;

    localparam int MAX_RANGE_TB = DEFAULT_MAX_RANGE;
    localparam int IDLE_LIMIT = 20000;
    // The one function code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FUNC_W-1:0] s_func = '0;
    logic [SLOT_W-1:0] s_slot = '0;
    logic signed [COORD_W-1:0] s_chunk_x = '0, s_chunk_z = '0;
    logic signed [COORD_W-1:0] s_camera_x = '0, s_camera_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SLOT_W-1:0] m_out_slot;
    logic signed [COORD_W-1:0] m_new_x, m_new_z;

    sliding_window_tile_reassigner dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_slot(s_slot),
        .s_chunk_x(s_chunk_x), .s_chunk_z(s_chunk_z),
        .s_camera_x(s_camera_x), .s_camera_z(s_camera_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_slot(m_out_slot),
        .m_new_x(m_new_x), .m_new_z(m_new_z)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state, mirroring the block's registers and tables.
    logic [RANGE_W-1:0] win_range;
    logic [COORD_W-1:0] half_span;
    logic [COORD_W-1:0] slot_x [STACK_DEPTH];
    logic [COORD_W-1:0] slot_z [STACK_DEPTH];
    logic [COORD_W-1:0] ctr_x, ctr_z;
    logic [SLOT_W-1:0] stale_stack [STACK_DEPTH];
    logic [2*COORD_W-1:0] fresh_stack [STACK_DEPTH];
    int unsigned stale_depth, fresh_depth;

    tile_word_t pending_words[$];
    reassign_t expected_reassigns[$];
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int moves_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 1'b0;
    bit word_taken = 1'b0;
    int idle_cycles = 0;

    function automatic longint tile_of(logic [COORD_W-1:0] pos);
        longint h, num, den, q;
        h = (half_span == 0) ? 1 : longint'(half_span);
        num = longint'($signed(pos)) + h;
        den = 2 * h;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic longint abs_diff(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic queue_word(tile_word_t w);
        pending_words = {pending_words, w};
    endtask

    // Applies one accepted word to the predictor and queues any result.
    task automatic predict_reassign(tile_word_t w);
        longint r, ix, iz, ocx, ocz, x, z;
        int unsigned slots, i;
        reassign_t res;
        if (w.func == FUNC_LOAD) begin
            slot_x[w.slot] = w.chunk_x;
            slot_z[w.slot] = w.chunk_z;
        end else if (w.func == FUNC_CENTER) begin
            ctr_x = w.chunk_x;
            ctr_z = w.chunk_z;
        end else if (w.func == FUNC_CAMERA) begin
            if (stale_depth > 0) begin
                // Pop the top stale slot and the fresh coordinate at the same depth.
                i = stale_depth - 1;
                res.slot = stale_stack[i];
                res.x = '0;
                res.z = '0;
                if (i < fresh_depth) begin
                    res.x = fresh_stack[i][COORD_W-1:0];
                    res.z = fresh_stack[i][2*COORD_W-1:COORD_W];
                end
                slot_x[res.slot] = res.x;
                slot_z[res.slot] = res.z;
                stale_depth--;
                if (fresh_depth > 0) fresh_depth--;
                expected_reassigns = {expected_reassigns, res};
            end else begin
                r = (win_range > MAX_RANGE_TB) ? MAX_RANGE_TB : win_range;
                // The x/z swap: tile x follows camera z and tile z follows camera x.
                ix = tile_of(w.camera_z);
                iz = tile_of(w.camera_x);
                ocx = $signed(ctr_x);
                ocz = $signed(ctr_z);
                if (ix != ocx || iz != ocz) begin
                    moves_seen++;
                    for (x = ix - r; x <= ix + r; x++)
                        for (z = iz - r; z <= iz + r; z++)
                            if (!(abs_diff(x, ocx) <= r && abs_diff(z, ocz) <= r)
                                    && fresh_depth < STACK_DEPTH) begin
                                fresh_stack[fresh_depth] = {z[31:0], x[31:0]};
                                fresh_depth++;
                            end
                    slots = (2 * r + 1) * (2 * r + 1);
                    for (i = 0; i < slots; i++)
                        if (!(abs_diff(ix, $signed(slot_x[i])) <= r &&
                              abs_diff(iz, $signed(slot_z[i])) <= r)
                                && stale_depth < STACK_DEPTH) begin
                            stale_stack[stale_depth] = i[SLOT_W-1:0];
                            stale_depth++;
                        end
                    ctr_x = ix[31:0];
                    ctr_z = iz[31:0];
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: presents queued words at the falling edge and keeps them
    // steady until the monitor has seen them accepted.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || word_taken) begin
                word_taken = 1'b0;
                if (pending_words.size() > 0 && !hold_send &&
                        $urandom_range(99) >= send_idle_pct) begin
                    tile_word_t w;
                    w = pending_words.pop_front();
                    {s_func, s_slot, s_chunk_x, s_chunk_z, s_camera_x, s_camera_z} <= w;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: feeds accepted words to the predictor and checks each result
    // word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_reassigns.size() == 0) begin
                    report_mismatch("unexpected result slot", m_out_slot, 0);
                end else begin
                    reassign_t e;
                    e = expected_reassigns.pop_front();
                    if (m_out_slot !== e.slot) report_mismatch("out_slot", m_out_slot, e.slot);
                    if (m_new_x !== e.x) report_mismatch("new_x", m_new_x, e.x);
                    if (m_new_z !== e.z) report_mismatch("new_z", m_new_z, e.z);
                end
            end
            if (s_valid && s_ready) begin
                words_sent++;
                word_taken = 1'b1;
                predict_reassign({s_func, s_slot, s_chunk_x, s_chunk_z,
                                  s_camera_x, s_camera_z});
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no word moved in %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Wait until the driver has handed off every queued word and all
    // expected results have drained, plus a margin for a silent camera move.
    task automatic drain_block();
        while (pending_words.size() > 0 || s_valid || expected_reassigns.size() > 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_WINDOW_RANGE) win_range = val[RANGE_W-1:0];
        else if (idx == CFG_TILE_HALF_SPAN) half_span = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic tile_word_t make_word(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
            logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        tile_word_t w;
        w = {f, s, a, b, c, d};
        return w;
    endfunction

    // A camera position near tile t for the current half span.
    function automatic logic [31:0] pos_for_tile(longint t);
        longint h;
        h = (half_span == 0) ? 1 : longint'(half_span);
        return 32'(2 * h * t + longint'($urandom_range(0, 2)) - 1);
    endfunction

    // Queues n camera words, each a pop while the stale stack is not empty; each pop causes one result.
    task automatic queue_pops(int n);
        repeat (n) queue_word(make_word(FUNC_CAMERA, SLOT_W'($urandom), $urandom,
            $urandom, $urandom, $urandom));
    endtask

    task automatic random_phase(int n);
        tile_word_t w;
        int kind;
        repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                w = make_word(FUNC_LOAD, SLOT_W'($urandom), $signed($urandom_range(0, 8)) - 4,
                    $signed($urandom_range(0, 8)) - 4, $urandom, $urandom);
            end else if (kind < 20) begin
                w = make_word(FUNC_LOAD, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
            end else if (kind < 25) begin
                w = make_word(FUNC_CENTER, SLOT_W'($urandom),
                    $signed($urandom_range(0, 6)) - 3, $signed($urandom_range(0, 6)) - 3,
                    $urandom, $urandom);
            end else if (kind < 27) begin
                w = make_word(FUNC_SPARE, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
            end else if (kind < 30) begin
                w = make_word(FUNC_CAMERA, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
            end else begin
                // Small camera walks keep the window moving a tile or two.
                w = make_word(FUNC_CAMERA, SLOT_W'($urandom), $urandom, $urandom,
                    pos_for_tile($signed(ctr_z) + $signed($urandom_range(0, 4)) - 2),
                    pos_for_tile($signed(ctr_x) + $signed($urandom_range(0, 4)) - 2));
            end
            queue_word(w);
        end
    endtask

    initial begin
        win_range = RESET_WINDOW_RANGE;
        half_span = RESET_HALF_SPAN;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            slot_x[i] = '0;
            slot_z[i] = '0;
        end
        ctr_x = '0;
        ctr_z = '0;
        stale_depth = 0;
        fresh_depth = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: every function, field extremes, unused code, a slot
        // beyond the window, a move that fills both stacks and its pops.
        queue_word(make_word(FUNC_LOAD, 8'hFF, 32'h7FFFFFFF, 32'h80000000, 0, 0));
        queue_word(make_word(FUNC_LOAD, 8'h00, 32'h80000000, 32'h7FFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_word(make_word(FUNC_SPARE, 8'hAA, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_word(make_word(FUNC_CAMERA, 0, 0, 0, 32'h00000000, 32'h00000000));
        queue_word(make_word(FUNC_CAMERA, 0, 0, 0, 32'h00030000, 32'hFFFD0000));
        queue_pops(12);
        queue_word(make_word(FUNC_CENTER, 8'h55, 32'h7FFFFFFF, 32'h80000000, 0, 0));
        queue_word(make_word(FUNC_CAMERA, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000));
        drain_block();
        // Flush whatever that extreme move pushed.
        while (stale_depth > 0) begin
            queue_pops(stale_depth);
            drain_block();
        end

        // Settings sweep, extremes included, with the idling phases.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            write_register(CFG_WINDOW_RANGE, (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7));
            write_register(CFG_TILE_HALF_SPAN, (ph == 2) ? 32'hFFFFFFFF :
                (ph == 3) ? 32'd1 : (ph == 4) ? 32'd0 : $urandom_range(1, 32'h40000));
            write_register(8'hF0, $urandom);
            random_phase(100);
            // Halfway through, hold the sender until every expected result
            // has arrived, then let it finish the phase.
            wait (pending_words.size() <= 50);
            hold_send = 1'b1;
            while (s_valid || expected_reassigns.size() > 0) @(posedge aclk);
            hold_send = 1'b0;
            drain_block();
            while (stale_depth > 0) begin
                queue_pops(stale_depth);
                drain_block();
            end
        end

        $display("Covered %0d words, %0d reassignments, %0d window moves.",
            words_sent, results_seen, moves_seen);
        if (errors == 0 && expected_reassigns.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/swtr_pkg.sv
hdl/swtr_div.sv
hdl/sliding_window_tile_reassigner.sv
test/sliding_window_tile_reassigner_test.sv
